@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define MD5D_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the condition.
`define MD5D_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/md5d_pkg.sv @@
`timescale 1ns / 1ps

package md5d_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       eom;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic init;
  } rnd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_stat_t;

  localparam logic [3:0][31:0] INIT_CHAIN = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMOUNT [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

endpackage

@@ hw/rtl/md5_message_digest_unit.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       request    in_valid, in_stall   data_byte, has_data, end_of_message
// out      result     out_valid, out_stall digest_word, word_index, last_word
//
// Each message byte is packed into the block buffer; every 64th byte starts a compression
// followed by the chaining add, and no byte is taken from the queue until it is done.
// An end mark adds a padding state, a length state, one or two compressions and
// four digest words.
// Reset clears the queue, the byte count and the block buffer, and loads the initial
// chaining words. The request side stalls only while the two-entry queue is full.

module md5_message_digest_unit
  import md5d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_data,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_nonempty;
  cmd_t q_head;

  md5d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  md5d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  md5d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_nonempty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

@@ hw/rtl/md5d_front.sv @@
`timescale 1ns / 1ps

module md5d_front
  import md5d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       has_data,
  input  logic       end_of_message,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic accepted;
  logic useful;

  // Requests with neither a byte nor an end mark are taken and dropped.
  assign useful   = has_data | end_of_message;
  assign in_stall = q_full;
  assign accepted = in_valid & ~q_full;
  assign q_push   = accepted & useful;

  always_comb begin
    q_cmd          = '0;
    q_cmd.data     = data_byte;
    q_cmd.has_data = has_data;
    q_cmd.eom      = end_of_message;
  end

  logic dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else begin
      dropped <= accepted & ~useful;
    end
  end

  `include "assert_macros.svh"

  `MD5D_ASSERT_NEXT(a_drop_no_push, clk, rst, accepted && !useful, dropped, "idle request not dropped")
  `MD5D_ASSERT_IMP(a_push_not_full, clk, rst, q_push, !q_full && !dropped || !q_full, "push into a full queue")
  `MD5D_ASSERT_IMP(a_stall_full, clk, rst, in_stall, !q_push, "push while stalled")

endmodule

@@ hw/rtl/md5d_queue.sv @@
`timescale 1ns / 1ps

module md5d_queue
  import md5d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];
  assign do_push  = push & ~full;
  assign do_pop   = pop & nonempty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/md5d_round.sv @@
`timescale 1ns / 1ps

module md5d_round
  import md5d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rnd_ctl_t         ctl,
  output rnd_stat_t        stat,
  output logic [3:0]       msg_idx,
  input  logic [31:0]      msg_word,
  output logic [3:0][31:0] chain
);

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [31:0] work [4];
  logic [1:0]  grp;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_next;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    rotl32 = t[63:32];
  endfunction

  assign grp = cnt[5:4];

  always_comb begin
    unique case (grp)
      2'd0: begin
        f       = (work[1] & work[2]) | (~work[1] & work[3]);
        msg_idx = cnt[3:0];
      end
      2'd1: begin
        f       = (work[1] & work[3]) | (work[2] & ~work[3]);
        msg_idx = 4'(4'd5 * cnt[3:0] + 4'd1);
      end
      2'd2: begin
        f       = work[1] ^ work[2] ^ work[3];
        msg_idx = 4'(4'd3 * cnt[3:0] + 4'd5);
      end
      default: begin
        f       = work[2] ^ (work[1] | ~work[3]);
        msg_idx = 4'(4'd7 * cnt[3:0]);
      end
    endcase
  end

  assign sum    = work[0] + f + msg_word + SINE_K[cnt];
  assign b_next = work[1] + rotl32(sum, ROT_AMOUNT[grp][cnt[1:0]]);

  assign stat.busy = busy;
  assign stat.done = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      cnt   <= '0;
      chain <= INIT_CHAIN;
    end else begin
      fin <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= 6'(cnt + 1'b1);
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        for (int k = 0; k < 4; k++) begin
          chain[k] <= chain[k] + work[k];
        end
      end
      if (ctl.init) begin
        chain <= INIT_CHAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int k = 0; k < 4; k++) begin
        work[k] <= chain[k];
      end
    end else if (busy) begin
      work[0] <= work[3];
      work[1] <= b_next;
      work[2] <= work[1];
      work[3] <= work[2];
    end
  end

endmodule

@@ hw/rtl/md5d_back.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module md5d_back
  import md5d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_COMP,
    S_OUT
  } state_t;

  state_t           state;
  state_t           after_comp;
  logic [31:0]      block_words [16];
  logic [60:0]      total;
  logic [1:0]       word_idx;
  logic [5:0]       pos;
  logic [63:0]      bit_len;
  rnd_ctl_t         rnd_ctl;
  rnd_stat_t        rnd_stat;
  logic [3:0]       msg_idx;
  logic [3:0][31:0] chain;

  assign pos     = total[5:0];
  assign bit_len = {total, 3'b000};
  assign q_pop   = (state == S_IDLE) && q_valid;

  always_comb begin
    rnd_ctl       = '0;
    rnd_ctl.start = (q_pop && q_head.has_data && (pos == 6'd63)) ||
                    ((state == S_PAD) && (pos >= 6'd56)) ||
                    (state == S_LEN);
    rnd_ctl.init  = (state == S_OUT) && !out_stall && (word_idx == 2'd3);
  end

  md5d_round u_round (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rnd_ctl),
    .stat     (rnd_stat),
    .msg_idx  (msg_idx),
    .msg_word (block_words[msg_idx]),
    .chain    (chain)
  );

  assign out_valid   = (state == S_OUT);
  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      after_comp <= S_IDLE;
      total      <= '0;
      word_idx   <= '0;
      for (int k = 0; k < 16; k++) begin
        block_words[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_head.has_data) begin
              block_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= q_head.data;
              total <= 61'(total + 1'b1);
              if (pos == 6'd63) begin
                state      <= S_COMP;
                after_comp <= q_head.eom ? S_PAD : S_IDLE;
              end else if (q_head.eom) begin
                state <= S_PAD;
              end
            end else if (q_head.eom) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          block_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= 8'h80;
          if (pos >= 6'd56) begin
            state      <= S_COMP;
            after_comp <= S_LEN;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          block_words[14] <= bit_len[31:0];
          block_words[15] <= bit_len[63:32];
          state           <= S_COMP;
          after_comp      <= S_OUT;
        end
        S_COMP: begin
          if (rnd_stat.done) begin
            for (int k = 0; k < 16; k++) begin
              block_words[k] <= '0;
            end
            state <= after_comp;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            word_idx <= 2'(word_idx + 1'b1);
            if (word_idx == 2'd3) begin
              total <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MD5D_ASSERT_IMP(a_out_core_idle, clk, rst, out_valid, !rnd_stat.busy && !rnd_stat.done, "digest shown while compression runs")
  `MD5D_ASSERT_IMP(a_start_core_idle, clk, rst, rnd_ctl.start, !rnd_stat.busy && !rnd_stat.done, "compression started while busy")
  `MD5D_ASSERT_NEXT(a_block_cleared, clk, rst, rnd_stat.done, (block_words[14] == 32'd0) && (block_words[15] == 32'd0), "block buffer not cleared")
  `MD5D_ASSERT_NEXT(a_word_step, clk, rst, out_valid && !out_stall && (word_idx != 2'd3), word_idx == 2'($past(word_idx) + 2'd1), "digest word skipped")

endmodule
